FILE: rtl/mpb_pkg.sv
package mpb_pkg;

  localparam int LEVEL_W      = 24;
  localparam int ENV_W        = LEVEL_W - 1;
  localparam int COEF_W       = 13;
  localparam int ATTACK_SHIFT = 16;
  localparam int PROD_W       = ENV_W + COEF_W;
  localparam int INC_W        = PROD_W - ATTACK_SHIFT;

  // 0.1 as 6554 / 65536
  localparam logic [COEF_W-1:0] ATTACK_COEF = COEF_W'(6554);
  localparam logic [ENV_W-1:0]  ENV_MAX     = '1;

  localparam int NUM_LANES  = 2;
  localparam int IN_DATA_W  = ((NUM_LANES * LEVEL_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * NUM_LANES * LEVEL_W + 7) / 8) * 8;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = LEVEL_W;

  localparam logic [CFG_ADDR_W-1:0] CFG_METER_MODE     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_STEREO_ENABLE  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_BALANCE_ENABLE = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_BALANCE_LEVEL  = 2'd3;

  localparam logic [1:0] MODE_PEAK     = 2'd1;
  localparam logic [1:0] MODE_RMS_PEAK = 2'd2;

  typedef struct packed {
    logic                      balance_enable;
    logic signed [LEVEL_W-1:0] balance_level;
  } lane_cfg_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] peak;
    logic [ENV_W-1:0]          env;
  } lane_out_t;

endpackage

FILE: rtl/mpb_lane.sv
module mpb_lane
  import mpb_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      upd,
  input  logic signed [LEVEL_W-1:0] level,
  input  logic                      preset,
  input  logic signed [LEVEL_W-1:0] preset_level,
  input  lane_cfg_t                 cfg,
  output lane_out_t                 state_nxt
);

  logic signed [LEVEL_W-1:0] peak_r, peak_nxt;
  logic [ENV_W-1:0]          env_r, env_nxt;

  logic                      jump;
  logic signed [LEVEL_W:0]   pdiff, pstep, psum;
  logic signed [LEVEL_W-1:0] peak_upd;

  logic [LEVEL_W-1:0]        mag;
  logic [ENV_W-1:0]          absval;
  logic signed [LEVEL_W-1:0] ediff, equarter, edown;
  logic [PROD_W-1:0]         prod;
  logic [ENV_W:0]            eup;
  logic [ENV_W-1:0]          env_upd;

  always_comb begin
    if (cfg.balance_enable && (level <= cfg.balance_level)) begin
      jump = (peak_r > level);
    end else if (cfg.balance_enable) begin
      jump = (peak_r <= level);
    end else begin
      jump = (peak_r < level);
    end
    pdiff = {level[LEVEL_W-1], level} - {peak_r[LEVEL_W-1], peak_r};
    pstep = pdiff >>> 2;
    psum  = {peak_r[LEVEL_W-1], peak_r} + pstep;
    // the quarter step always lands between old peak and level
    peak_upd = jump ? level : psum[LEVEL_W-1:0];
  end

  always_comb begin
    mag    = level[LEVEL_W-1] ? LEVEL_W'(-level) : LEVEL_W'(level);
    // most negative level has no positive twin
    absval = mag[LEVEL_W-1] ? ENV_MAX : mag[ENV_W-1:0];
    ediff  = $signed({1'b0, absval}) - $signed({1'b0, env_r});
    prod   = PROD_W'(ediff[ENV_W-1:0]) * PROD_W'(ATTACK_COEF);
    eup    = {1'b0, env_r} + (ENV_W+1)'(prod[PROD_W-1:ATTACK_SHIFT]);
    equarter = ediff >>> 2;
    edown  = $signed({1'b0, env_r}) + equarter;
    if (!ediff[LEVEL_W-1] && (ediff != '0)) begin
      env_upd = eup[ENV_W] ? ENV_MAX : eup[ENV_W-1:0];
    end else begin
      env_upd = edown[LEVEL_W-1] ? '0 : edown[ENV_W-1:0];
    end
  end

  always_comb begin
    peak_nxt = peak_r;
    env_nxt  = env_r;
    if (preset) begin
      peak_nxt = preset_level;
    end else if (upd) begin
      peak_nxt = peak_upd;
      env_nxt  = env_upd;
    end
    state_nxt.peak = peak_nxt;
    state_nxt.env  = env_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
      env_r  <= '0;
    end else begin
      peak_r <= peak_nxt;
      env_r  <= env_nxt;
    end
  end

  a_preset_loads: assert property (@(posedge clk) disable iff (!rst_n)
    preset |=> peak_r == $past(preset_level))
    else $error("peak not preset to balance level");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !preset && !upd |=> $stable(peak_r) && $stable(env_r))
    else $error("lane state moved without an item");

  a_jump_takes_level: assert property (@(posedge clk) disable iff (!rst_n)
    !preset && upd && jump |=> peak_r == $past(level))
    else $error("peak did not jump to level");

endmodule

FILE: rtl/mpb_merge.sv
module mpb_merge
  import mpb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [1:0]            meter_mode,
  input  lane_out_t             lane_res [NUM_LANES],
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic [OUT_DATA_W-1:0] item;
  logic [OUT_DATA_W-1:0] main_r, main_nxt, skid_r, skid_nxt;
  logic                  main_valid_r, main_valid_nxt, skid_valid_r, skid_valid_nxt;
  logic                  pop;

  always_comb begin
    item = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      item[i*LEVEL_W +: LEVEL_W] = (meter_mode == MODE_RMS_PEAK) ?
                                   LEVEL_W'(lane_res[i].env) : lane_res[i].peak;
      item[(NUM_LANES+i)*LEVEL_W +: LEVEL_W] = lane_res[i].peak;
    end
  end

  assign pop       = main_valid_r && out_tready;
  assign in_tready = !skid_valid_r;

  always_comb begin
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (push && (!main_valid_r || pop)) begin
      main_nxt       = item;
      main_valid_nxt = 1'b1;
    end else if (push) begin
      skid_nxt       = item;
      skid_valid_nxt = 1'b1;
    end else if (pop && skid_valid_r) begin
      main_nxt       = skid_r;
      skid_valid_nxt = 1'b0;
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = main_valid_r;
  assign out_tdata  = main_r;

  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid entry held with empty output stage");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !pop |=> skid_valid_r && $stable(skid_r))
    else $error("skid entry lost while output stalled");

  a_item_lands: assert property (@(posedge clk) disable iff (!rst_n)
    push && (!main_valid_r || pop) |=> main_valid_r && main_r == $past(item))
    else $error("item not loaded into output stage");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    pop && skid_valid_r |=> main_valid_r && main_r == $past(skid_r))
    else $error("skid entry not moved to output stage");

endmodule

FILE: rtl/meter_peak_rms_ballistics_core.sv
// Peak and envelope level meter for two channels. Each input item is one meter tick carrying
// the latest left and right levels (signed, 20 fractional bits); each tick returns one
// result with the shown value and the peak tracker value of both channels. Without balance
// the peak jumps to a louder level (with balance, down to a level at or below the balance
// level, else up); otherwise it moves a quarter of the way toward it. The envelope of the
// absolute level rises by 0.1 and falls by 0.25 of the difference. Both channels run in
// parallel lanes, so one item is taken every clock cycle unless the output stage is full;
// each lane uses one 23x13 constant multiply and adds. A two-entry output stage lets input
// keep flowing while a result waits. The user must write configuration only while idle;
// the block does not enforce it. Writing the balance level also presets both peak trackers
// to it. In mono only the left channel is updated and the right values are reported as held.
module meter_peak_rms_ballistics_core
  import mpb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // level_left, level_right
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // display_left, display_right, peak_left, peak_right
  input  logic                  cfg_wen,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [1:0]                meter_mode_r, meter_mode_nxt;
  logic                      stereo_r, stereo_nxt;
  logic                      bal_en_r, bal_en_nxt;
  logic signed [LEVEL_W-1:0] bal_lvl_r, bal_lvl_nxt;

  logic                      push;
  logic                      preset;
  logic                      lane_upd [NUM_LANES];
  lane_cfg_t                 lane_cfg;
  lane_out_t                 lane_res [NUM_LANES];

  always_comb begin
    meter_mode_nxt = meter_mode_r;
    stereo_nxt     = stereo_r;
    bal_en_nxt     = bal_en_r;
    bal_lvl_nxt    = bal_lvl_r;
    if (cfg_wen) begin
      case (cfg_addr)
        CFG_METER_MODE:     meter_mode_nxt = cfg_wdata[1:0];
        CFG_STEREO_ENABLE:  stereo_nxt     = cfg_wdata[0];
        CFG_BALANCE_ENABLE: bal_en_nxt     = cfg_wdata[0];
        CFG_BALANCE_LEVEL:  bal_lvl_nxt    = $signed(cfg_wdata[LEVEL_W-1:0]);
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meter_mode_r <= MODE_PEAK;
      stereo_r     <= 1'b0;
      bal_en_r     <= 1'b0;
      bal_lvl_r    <= '0;
    end else begin
      meter_mode_r <= meter_mode_nxt;
      stereo_r     <= stereo_nxt;
      bal_en_r     <= bal_en_nxt;
      bal_lvl_r    <= bal_lvl_nxt;
    end
  end

  assign push   = in_tvalid && in_tready;
  assign preset = cfg_wen && (cfg_addr == CFG_BALANCE_LEVEL);

  assign lane_cfg.balance_enable = bal_en_r;
  assign lane_cfg.balance_level  = bal_lvl_r;

  // left lane always runs, right lane only in stereo
  assign lane_upd[0] = push;
  assign lane_upd[1] = push && stereo_r;

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    mpb_lane u_lane (
      .clk          (clk),
      .rst_n        (rst_n),
      .upd          (lane_upd[i]),
      .level        ($signed(in_tdata[i*LEVEL_W +: LEVEL_W])),
      .preset       (preset),
      .preset_level ($signed(cfg_wdata[LEVEL_W-1:0])),
      .cfg          (lane_cfg),
      .state_nxt    (lane_res[i])
    );
  end

  mpb_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .meter_mode (meter_mode_r),
    .lane_res   (lane_res),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
